/* src/delay_slot_pool_unit_macros.svh */
// ----------------------------------------------------------------------------
// delay_slot_pool_unit_macros: assertion shorthands
// Same-cycle and next-cycle implications, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef DELAY_SLOT_POOL_UNIT_MACROS_SVH
`define DELAY_SLOT_POOL_UNIT_MACROS_SVH

// ante implies cons in the same cycle
`define DSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("delay slot pool check failed");

// ante implies cons in the next cycle
`define DSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("delay slot pool check failed");

`endif

/* src/dsp_pkg.sv */
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared types and constants of the delay slot pool.
// ----------------------------------------------------------------------------
`default_nettype none

package dsp_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int POOLS_DEF = 4;

    localparam int REQ_W  = 3;
    localparam int POOL_W = 2;
    localparam int SLOT_W = 4;
    localparam int DLY_W  = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK    = 3'd0,
        REQ_ALLOC   = 3'd1,
        REQ_RESTART = 3'd2,
        REQ_RELEASE = 3'd3,
        REQ_QUERY   = 3'd4
    } t_req_type;

    // per-cell controls
    typedef struct packed {
        logic tick;
        logic load;
        logic clr;
    } t_cell_ctl;

    // per-pool commands
    typedef struct packed {
        logic tick;
        logic restart;
        logic release_slot;
        logic seed;
    } t_pool_cmd;

endpackage

`default_nettype wire

/* src/dsp_cell.sv */
// ----------------------------------------------------------------------------
// dsp_cell
// One delay slot: busy, count and done; passes the allocation token on.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_cell (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire dsp_pkg::t_cell_ctl      i_ctl,
    input  wire logic [dsp_pkg::DLY_W-1:0] i_dly,
    input  wire logic                    i_tok,
    output logic                         o_tok,
    output logic                         o_claim,
    output logic                         o_done
);
    import dsp_pkg::*;

    logic             r_tok;
    logic             r_busy;
    logic             r_done;
    logic [DLY_W-1:0] r_count;

    // token stops at the first free slot, otherwise moves on
    assign o_claim = r_tok & ~r_busy;
    assign o_tok   = r_tok & r_busy;
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= 1'b0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_tok <= i_tok;
            if (i_ctl.clr) begin
                r_busy  <= 1'b0;
                r_done  <= 1'b0;
                r_count <= '0;
            end else if (i_ctl.load || o_claim) begin
                r_busy  <= 1'b1;
                r_done  <= 1'b0;
                r_count <= i_dly;
            end else if (i_ctl.tick && r_busy) begin
                if (r_count != '0) begin
                    r_count <= r_count - DLY_W'(1);
                end
                // reaches or sits at zero
                if (r_count <= DLY_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* src/dsp_pool.sv */
// ----------------------------------------------------------------------------
// dsp_pool
// Chain of slot cells for one timer channel; token scans for a free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_pool #(
    parameter int SLOTS = dsp_pkg::SLOTS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire dsp_pkg::t_pool_cmd         i_cmd,
    input  wire logic [dsp_pkg::SLOT_W-1:0] i_slot,
    input  wire logic [dsp_pkg::DLY_W-1:0]  i_dly,
    output logic                            o_claim,
    output logic                            o_tail,
    output logic                            o_done_sel
);
    import dsp_pkg::*;

    logic [SLOTS:0]   tok;
    logic [SLOTS-1:0] claim;
    logic [SLOTS-1:0] done;
    logic [SLOTS-1:0] hit;

    assign tok[0] = i_cmd.seed;

    for (genvar s = 0; s < SLOTS; s++) begin : g_cell
        t_cell_ctl ctl;

        assign hit[s]   = (int'(i_slot) == s);
        assign ctl.tick = i_cmd.tick;
        assign ctl.load = i_cmd.restart & hit[s];
        assign ctl.clr  = i_cmd.release_slot & hit[s];

        dsp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_dly   (i_dly),
            .i_tok   (tok[s]),
            .o_tok   (tok[s+1]),
            .o_claim (claim[s]),
            .o_done  (done[s])
        );
    end

    assign o_claim    = |claim;
    assign o_tail     = tok[SLOTS];
    assign o_done_sel = |(done & hit);

endmodule

`default_nettype wire

/* src/delay_slot_pool_unit.sv */
// ----------------------------------------------------------------------------
// delay_slot_pool_unit
// Pools of countdown delay slots, one chain of slot cells per timer channel.
// ----------------------------------------------------------------------------
//  channel   | handshake                  | fields
//  request   | start, busy                | i_req_type i_pool i_slot i_delay_ticks
//  result    | o_valid (one-cycle strobe) | o_status o_slot_out o_done_res
//
//  Tick, restart, release, query and unknown requests: result strobes the
//  cycle after accept; busy stays low, so one such request per cycle.
//  Allocate to an existing pool: a token walks the pool's cell chain one slot
//  per cycle; the result comes once it claims the first free slot or leaves a
//  full pool, busy high meanwhile. Synchronous active-low reset clears every slot.
//  Results cannot be held off; each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module delay_slot_pool_unit #(
    parameter int SLOTS = dsp_pkg::SLOTS_DEF,
    parameter int POOLS = dsp_pkg::POOLS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [dsp_pkg::REQ_W-1:0]  i_req_type,
    input  wire logic [dsp_pkg::POOL_W-1:0] i_pool,
    input  wire logic [dsp_pkg::SLOT_W-1:0] i_slot,
    input  wire logic [dsp_pkg::DLY_W-1:0]  i_delay_ticks,
    output logic                            o_valid,
    output logic                            o_status,
    output logic [dsp_pkg::SLOT_W-1:0]      o_slot_out,
    output logic                            o_done_res
);
    import dsp_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_HUNT
    } t_state;

    t_state           r_state;
    logic [SW-1:0]    r_scan;
    logic [DLY_W-1:0] r_dly;
    logic             r_valid;
    logic             r_status;
    logic [SLOT_W-1:0] r_slot_out;
    logic             r_done_res;

    logic             acc;
    logic             acc_tick;
    logic             acc_alloc;
    logic             acc_restart;
    logic             acc_release;
    logic             acc_query;
    logic [POOLS-1:0] pool_hit;
    logic [POOLS-1:0] claim;
    logic [POOLS-1:0] tail;
    logic [POOLS-1:0] done_sel;
    logic             any_claim;
    logic             any_tail;
    logic             pool_ok;
    logic             done_q;
    logic [DLY_W-1:0] cell_dly;
    logic [SW+SLOT_W-1:0] scan_ext;

    assign acc = start & ~busy;

    always_comb begin
        acc_tick    = 1'b0;
        acc_alloc   = 1'b0;
        acc_restart = 1'b0;
        acc_release = 1'b0;
        acc_query   = 1'b0;
        unique case (t_req_type'(i_req_type))
            REQ_TICK:    acc_tick    = acc;
            REQ_ALLOC:   acc_alloc   = acc;
            REQ_RESTART: acc_restart = acc;
            REQ_RELEASE: acc_release = acc;
            REQ_QUERY:   acc_query   = acc;
            default: ;
        endcase
    end

    // restart loads the live operand; the scan loads the one captured at accept
    assign cell_dly = (r_state == ST_HUNT) ? r_dly : i_delay_ticks;

    for (genvar p = 0; p < POOLS; p++) begin : g_pool
        t_pool_cmd cmd;

        assign pool_hit[p]      = (int'(i_pool) == p);
        assign cmd.tick         = acc_tick & pool_hit[p];
        assign cmd.restart      = acc_restart & pool_hit[p];
        assign cmd.release_slot = acc_release & pool_hit[p];
        assign cmd.seed         = acc_alloc & pool_hit[p];

        dsp_pool #(
            .SLOTS (SLOTS)
        ) u_pool (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_slot     (i_slot),
            .i_dly      (cell_dly),
            .o_claim    (claim[p]),
            .o_tail     (tail[p]),
            .o_done_sel (done_sel[p])
        );
    end

    assign pool_ok   = |pool_hit;
    assign any_claim = |claim;
    assign any_tail  = |tail;
    assign done_q    = |(done_sel & pool_hit);
    assign scan_ext  = {{SLOT_W{1'b0}}, r_scan};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_scan     <= '0;
            r_valid    <= 1'b0;
            r_status   <= 1'b0;
            r_slot_out <= '0;
            r_done_res <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        r_status   <= 1'b0;
                        r_slot_out <= '0;
                        r_done_res <= 1'b0;
                        if (acc_alloc && pool_ok) begin
                            r_state <= ST_HUNT;
                            r_scan  <= '0;
                        end else begin
                            r_valid <= 1'b1;
                            if (acc_alloc) begin
                                r_status <= 1'b1;
                            end
                            if (acc_restart || acc_release || acc_query) begin
                                r_slot_out <= i_slot;
                            end
                            if (acc_query) begin
                                r_done_res <= done_q;
                            end
                        end
                    end
                end
                ST_HUNT: begin
                    if (any_claim) begin
                        r_state    <= ST_IDLE;
                        r_valid    <= 1'b1;
                        r_slot_out <= scan_ext[SLOT_W-1:0];
                    end else if (any_tail) begin
                        // pool full
                        r_state  <= ST_IDLE;
                        r_valid  <= 1'b1;
                        r_status <= 1'b1;
                    end else begin
                        r_scan <= r_scan + SW'(1);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_alloc) begin
            r_dly <= i_delay_ticks;
        end
    end

    assign busy       = (r_state == ST_HUNT);
    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_slot_out = r_slot_out;
    assign o_done_res = r_done_res;

endmodule

`default_nettype wire

/* src/dsp_checker.sv */
// ----------------------------------------------------------------------------
// dsp_checker
// Port-level checks of the delay slot pool, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "delay_slot_pool_unit_macros.svh"

module dsp_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    input  wire logic                       busy,
    input  wire logic [dsp_pkg::REQ_W-1:0]  i_req_type,
    input  wire logic                       o_valid,
    input  wire logic                       o_status,
    input  wire logic [dsp_pkg::SLOT_W-1:0] o_slot_out,
    input  wire logic                       o_done_res
);
    import dsp_pkg::*;

    // a result beat never overlaps a running scan
    `DSP_ASSERT_NOW(a_no_beat_busy, i_clk, i_rst_n, o_valid, !busy)

    // everything but allocate answers on the next cycle
    `DSP_ASSERT_NEXT(a_quick_answer, i_clk, i_rst_n,
        start && !busy && (i_req_type != REQ_ALLOC), o_valid && !busy)

    // a full pool reports no slot and no done
    `DSP_ASSERT_NOW(a_full_clean, i_clk, i_rst_n, o_valid && o_status,
        (o_slot_out == '0) && !o_done_res)

    // busy only follows an accepted allocate
    `DSP_ASSERT_NOW(a_busy_src, i_clk, i_rst_n, $rose(busy),
        $past(start) && (($past(i_req_type)) == REQ_ALLOC))

    // a result beat always traces back to a request
    `DSP_ASSERT_NOW(a_beat_src, i_clk, i_rst_n, o_valid, $past(busy) || $past(start))

endmodule

bind delay_slot_pool_unit dsp_checker u_dsp_checker (.*);

`default_nettype wire
